// ===== rtl/async_frame_accumulator_ager_defines.svh =====
// Assertion macros for the accumulator RTL.
`ifndef ASYNC_FRAME_ACCUMULATOR_AGER_DEFINES_SVH
`define ASYNC_FRAME_ACCUMULATOR_AGER_DEFINES_SVH

// Checked on every rising edge outside reset.
`define AFA_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define AFA_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== rtl/afa_pkg.sv =====
// ----------------------------------------------------------------------------
// afa_pkg
// Constants, types and arithmetic helpers of the frame accumulator.
// ----------------------------------------------------------------------------
package afa_pkg;

  localparam int MAX_WIDTH  = 256;
  localparam int MAX_HEIGHT = 256;
  localparam int COLOR_BITS = 21;

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH + 1);
  localparam int WW    = $clog2(MAX_WIDTH + 1);
  localparam int HW    = $clog2(MAX_HEIGHT + 1);
  localparam int SW    = 34;

  localparam longint CMAX = (longint'(1) << (COLOR_BITS - 1)) - 1;
  localparam longint CMIN = -CMAX - 1;
  localparam longint OMAX = 8388607;
  localparam longint OMIN = -8388608;

  localparam logic [14:0] FADE_Q15 = 15'd29491;
  localparam int          FADE_RND = 16384;

  typedef enum logic [2:0] {
    OC_ADDED    = 3'd0,
    OC_REPLACED = 3'd1,
    OC_STASHED  = 3'd2,
    OC_IGNORED  = 3'd3,
    OC_DROPPED  = 3'd4
  } outcome_e;

  typedef enum logic [1:0] {
    CFG_WIDTH   = 2'd0,
    CFG_HEIGHT  = 2'd1,
    CFG_MAX_AGE = 2'd2,
    CFG_FADE    = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [2:0][COLOR_BITS-1:0] vis;
    logic [2:0][COLOR_BITS-1:0] stash;
    logic [15:0]                pframe;
    logic [15:0]                sframe;
    logic [31:0]                ptime;
  } ent_t;

  localparam int EW = $bits(ent_t);

  typedef struct packed {
    logic accept;
    logic sread;
    logic sweep;
    logic sweep_tick;
    logic clr;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic in_valid;
    logic in_kind;
    logic in_newer;
    logic sweep_done;
    logic clear_done;
    logic out_free;
  } status_t;

  function automatic logic [WW-1:0] used_w(logic [8:0] v);
    if (v == 9'd0) return WW'(1);
    if (32'(v) > MAX_WIDTH) return WW'(MAX_WIDTH);
    return WW'(v);
  endfunction

  function automatic logic [HW-1:0] used_h(logic [8:0] v);
    if (v == 9'd0) return HW'(1);
    if (32'(v) > MAX_HEIGHT) return HW'(MAX_HEIGHT);
    return HW'(v);
  endfunction

  function automatic logic [AW-1:0] pix_addr(logic [7:0] x, logic [7:0] y,
                                             logic [WW-1:0] w);
    logic [WW+8:0] a;
    a = (WW+9)'(y) * (WW+9)'(w) + (WW+9)'(x);
    return a[AW-1:0];
  endfunction

  // Result carries the clip flag above the value.
  function automatic logic [COLOR_BITS:0] clip(logic signed [SW-1:0] v);
    if (v > SW'(CMAX)) return {1'b1, COLOR_BITS'(CMAX)};
    if (v < SW'(CMIN)) return {1'b1, COLOR_BITS'(CMIN)};
    return {1'b0, v[COLOR_BITS-1:0]};
  endfunction

  function automatic logic signed [23:0] out24(logic [COLOR_BITS-1:0] v);
    logic signed [SW-1:0] s;
    s = SW'($signed(v));
    if (s > SW'(OMAX)) return 24'sd8388607;
    if (s < SW'(OMIN)) return -24'sd8388608;
    return s[23:0];
  endfunction

  function automatic logic [COLOR_BITS-1:0] fade(logic [COLOR_BITS-1:0] v);
    logic [COLOR_BITS:0]    mag;
    logic [COLOR_BITS+15:0] prod;
    logic [COLOR_BITS:0]    r;
    mag  = v[COLOR_BITS-1] ? (COLOR_BITS+1)'(-$signed(v)) : (COLOR_BITS+1)'(v);
    prod = (COLOR_BITS+16)'(mag) * (COLOR_BITS+16)'(FADE_Q15)
         + (COLOR_BITS+16)'(FADE_RND);
    r    = prod[COLOR_BITS+15:15];
    return v[COLOR_BITS-1] ? COLOR_BITS'(-r) : COLOR_BITS'(r);
  endfunction

endpackage

// ===== rtl/afa_ram.sv =====
// ----------------------------------------------------------------------------
// afa_ram
// Generic RAM with one write port and one registered read port.
// ----------------------------------------------------------------------------
module afa_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/afa_ctrl.sv =====
// ----------------------------------------------------------------------------
// afa_ctrl
// Sequencer: clearing pass, item intake, pixel sweeps and sample commit.
// ----------------------------------------------------------------------------
module afa_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  afa_pkg::status_t status_i,
  output afa_pkg::cmd_t    cmd_o,
  output logic             in_stall_o
);

  typedef enum logic [5:0] {
    ST_CLEAR  = 6'b000001,
    ST_IDLE   = 6'b000010,
    ST_FSWEEP = 6'b000100,
    ST_SREAD  = 6'b001000,
    ST_SWRITE = 6'b010000,
    ST_TSWEEP = 6'b100000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_CLEAR: begin
        cmd_o.clr = 1'b1;
        if (status_i.clear_done) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (status_i.in_valid) begin
          cmd_o.accept = 1'b1;
          if (status_i.in_kind) state_d = ST_TSWEEP;
          else if (status_i.in_newer) state_d = ST_FSWEEP;
          else state_d = ST_SWRITE;
        end
      end
      ST_FSWEEP: begin
        cmd_o.sweep = 1'b1;
        if (status_i.sweep_done) state_d = ST_SREAD;
      end
      ST_SREAD: begin
        cmd_o.sread = 1'b1;
        state_d     = ST_SWRITE;
      end
      ST_SWRITE: begin
        // The result register must be free before the pixel is committed.
        if (status_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      ST_TSWEEP: begin
        cmd_o.sweep      = 1'b1;
        cmd_o.sweep_tick = 1'b1;
        if (status_i.sweep_done) state_d = ST_IDLE;
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != ST_IDLE);

endmodule

// ===== rtl/afa_datapath.sv =====
// ----------------------------------------------------------------------------
// afa_datapath
// Pixel store, configuration, frame and tick state, per-pixel update and result register.
// ----------------------------------------------------------------------------
module afa_datapath (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  afa_pkg::cmd_t       cmd_i,
  output afa_pkg::status_t    status_o,
  input  logic                in_valid_i,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_idx_i,
  input  logic [15:0]         cfg_data_i,
  input  logic                kind_i,
  input  logic [7:0]          pixel_x_i,
  input  logic [7:0]          pixel_y_i,
  input  logic [15:0]         frame_number_i,
  input  logic signed [23:0]  red_in_i,
  input  logic signed [23:0]  green_in_i,
  input  logic signed [23:0]  blue_in_i,
  input  logic                batch_end_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [7:0]          out_x_o,
  output logic [7:0]          out_y_o,
  output logic signed [23:0]  visible_red_o,
  output logic signed [23:0]  visible_green_o,
  output logic signed [23:0]  visible_blue_o,
  output logic [2:0]          outcome_o,
  output logic                saturated_o,
  output logic                batch_last_o
);

  localparam int CB = afa_pkg::COLOR_BITS;
  localparam int AW = afa_pkg::AW;
  localparam int CW = afa_pkg::CW;
  localparam int SW = afa_pkg::SW;

  logic [8:0]  width_q, height_q;
  logic [15:0] max_age_q, fade_q;
  logic [31:0] tick_q;
  logic [15:0] cur_q;
  logic        has_q;

  logic [7:0]             x_q, y_q;
  logic [15:0]            f_q;
  logic [2:0][23:0]       c_q;
  logic                   be_q, stale_q;

  logic [CW-1:0] cnt_q;
  logic          pend_q;
  logic [AW-1:0] wa_q;

  logic                 out_valid_q;
  logic [7:0]           ox_q, oy_q;
  logic [2:0][23:0]     ovis_q;
  afa_pkg::outcome_e    oc_q;
  logic                 osat_q;
  logic                 obe_q;

  logic [afa_pkg::WW-1:0] w;
  logic [afa_pkg::HW-1:0] h;
  logic [CW-1:0]          npix;
  logic                   in_newer, in_stale, out_free;
  logic [AW-1:0]          item_addr;

  logic                 ram_we, ram_re;
  logic [AW-1:0]        ram_waddr, ram_raddr;
  afa_pkg::ent_t        ram_wdata, e;
  logic [afa_pkg::EW-1:0] ram_rdata;

  afa_pkg::ent_t se;
  logic [31:0]   age;
  logic          age_cond;

  afa_pkg::ent_t     ne;
  afa_pkg::outcome_e outc;
  logic              sat, wr, inimg, neg;
  logic [CB:0]       cl;
  logic [2:0][23:0]  vis_out;

  assign w         = afa_pkg::used_w(width_q);
  assign h         = afa_pkg::used_h(height_q);
  assign npix      = CW'(w * h);
  assign in_newer  = !has_q || (frame_number_i > cur_q);
  assign in_stale  = has_q && (frame_number_i < cur_q);
  assign out_free  = !out_valid_q || !out_stall_i;
  assign item_addr = afa_pkg::pix_addr(x_q, y_q, w);
  assign e         = afa_pkg::ent_t'(ram_rdata);

  assign status_o.in_valid   = in_valid_i;
  assign status_o.in_kind    = kind_i;
  assign status_o.in_newer   = in_newer;
  assign status_o.sweep_done = (cnt_q == npix) && !pend_q;
  assign status_o.clear_done = (cnt_q == CW'(afa_pkg::DEPTH));
  assign status_o.out_free   = out_free;

  afa_ram #(
    .Width(afa_pkg::EW),
    .Depth(afa_pkg::DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // Per-pixel update of a sweep: age restart or ageing.
  always_comb begin
    se       = e;
    age      = tick_q - e.ptime;
    age_cond = has_q && (e.pframe != 16'd0) && (e.pframe < cur_q)
            && (age > 32'(max_age_q));
    if (cmd_i.sweep_tick) begin
      if (age_cond) begin
        if (33'(age) > 33'(max_age_q) + 33'(fade_q)) begin
          se.ptime  = tick_q;
          se.pframe = cur_q;
          se.vis    = '0;
        end else begin
          for (int k = 0; k < 3; k++) se.vis[k] = afa_pkg::fade(e.vis[k]);
        end
      end
    end else begin
      se.ptime = tick_q;
    end
  end

  // Sample update of the addressed pixel.
  always_comb begin
    ne      = e;
    outc    = afa_pkg::OC_DROPPED;
    sat     = 1'b0;
    wr      = 1'b0;
    cl      = '0;
    vis_out = '0;
    inimg   = (16'(x_q) < 16'(w)) && (16'(y_q) < 16'(h));
    neg     = c_q[0][23] || c_q[1][23] || c_q[2][23];
    if (!stale_q && inimg) begin
      wr = 1'b1;
      if (e.pframe == f_q) begin
        outc = afa_pkg::OC_ADDED;
        for (int k = 0; k < 3; k++) begin
          cl        = afa_pkg::clip(SW'($signed(e.vis[k])) + SW'($signed(c_q[k])));
          ne.vis[k] = cl[CB-1:0];
          sat       = sat | cl[CB];
        end
      end else if (neg) begin
        if (e.sframe == f_q) begin
          outc = afa_pkg::OC_STASHED;
          for (int k = 0; k < 3; k++) begin
            cl          = afa_pkg::clip(SW'($signed(e.stash[k])) + SW'($signed(c_q[k])));
            ne.stash[k] = cl[CB-1:0];
            sat         = sat | cl[CB];
          end
        end else if (e.sframe < f_q) begin
          outc      = afa_pkg::OC_STASHED;
          ne.sframe = f_q;
          for (int k = 0; k < 3; k++) begin
            cl          = afa_pkg::clip(SW'($signed(c_q[k])));
            ne.stash[k] = cl[CB-1:0];
            sat         = sat | cl[CB];
          end
        end else begin
          outc = afa_pkg::OC_IGNORED;
        end
      end else begin
        outc      = afa_pkg::OC_REPLACED;
        ne.pframe = f_q;
        // The frame is current by now, so a stash of this frame is absorbed.
        if (e.sframe == f_q) begin
          for (int k = 0; k < 3; k++) begin
            cl          = afa_pkg::clip(SW'($signed(e.stash[k])) + SW'($signed(c_q[k])));
            ne.vis[k]   = cl[CB-1:0];
            ne.stash[k] = '0;
            sat         = sat | cl[CB];
          end
        end else begin
          for (int k = 0; k < 3; k++) begin
            cl        = afa_pkg::clip(SW'($signed(c_q[k])));
            ne.vis[k] = cl[CB-1:0];
            sat       = sat | cl[CB];
          end
        end
      end
    end
    if (inimg) begin
      for (int k = 0; k < 3; k++) vis_out[k] = afa_pkg::out24(ne.vis[k]);
    end
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = '0;
    if (cmd_i.clr && (cnt_q < CW'(afa_pkg::DEPTH))) begin
      ram_we    = 1'b1;
      ram_waddr = cnt_q[AW-1:0];
    end else if (cmd_i.sweep && pend_q) begin
      ram_we    = 1'b1;
      ram_waddr = wa_q;
      ram_wdata = se;
    end else if (cmd_i.commit && wr) begin
      ram_we    = 1'b1;
      ram_waddr = item_addr;
      ram_wdata = ne;
    end
  end

  always_comb begin
    ram_re    = 1'b0;
    ram_raddr = '0;
    if (cmd_i.accept) begin
      ram_re    = 1'b1;
      ram_raddr = afa_pkg::pix_addr(pixel_x_i, pixel_y_i, w);
    end else if (cmd_i.sread) begin
      ram_re    = 1'b1;
      ram_raddr = item_addr;
    end else if (cmd_i.sweep && (cnt_q < npix)) begin
      ram_re    = 1'b1;
      ram_raddr = cnt_q[AW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q   <= 9'd256;
      height_q  <= 9'd256;
      max_age_q <= 16'd30;
      fade_q    <= 16'd10;
    end else if (cfg_we_i) begin
      unique case (afa_pkg::cfg_idx_e'(cfg_idx_i))
        afa_pkg::CFG_WIDTH:   width_q   <= cfg_data_i[8:0];
        afa_pkg::CFG_HEIGHT:  height_q  <= cfg_data_i[8:0];
        afa_pkg::CFG_MAX_AGE: max_age_q <= cfg_data_i;
        afa_pkg::CFG_FADE:    fade_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_q <= '0;
      cur_q  <= '0;
      has_q  <= 1'b0;
      cnt_q  <= '0;
      pend_q <= 1'b0;
    end else begin
      if (cmd_i.accept) begin
        cnt_q  <= '0;
        pend_q <= 1'b0;
        if (kind_i) begin
          tick_q <= tick_q + 32'd1;
        end else if (in_newer) begin
          cur_q <= frame_number_i;
          has_q <= 1'b1;
        end
      end else if (cmd_i.clr && (cnt_q < CW'(afa_pkg::DEPTH))) begin
        cnt_q <= cnt_q + CW'(1);
      end else if (cmd_i.sweep) begin
        if (cnt_q < npix) begin
          cnt_q  <= cnt_q + CW'(1);
          pend_q <= 1'b1;
        end else begin
          pend_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      x_q     <= pixel_x_i;
      y_q     <= pixel_y_i;
      f_q     <= frame_number_i;
      c_q     <= {blue_in_i, green_in_i, red_in_i};
      be_q    <= batch_end_i;
      stale_q <= in_stale;
    end
    if (cmd_i.sweep) begin
      wa_q <= cnt_q[AW-1:0];
    end
    if (cmd_i.commit) begin
      ox_q   <= x_q;
      oy_q   <= y_q;
      ovis_q <= vis_out;
      oc_q   <= outc;
      osat_q <= sat;
      obe_q  <= be_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.commit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign out_x_o         = ox_q;
  assign out_y_o         = oy_q;
  assign visible_red_o   = ovis_q[0];
  assign visible_green_o = ovis_q[1];
  assign visible_blue_o  = ovis_q[2];
  assign outcome_o       = oc_q;
  assign saturated_o     = osat_q;
  assign batch_last_o    = obe_q;

endmodule

// ===== rtl/async_frame_accumulator_ager.sv =====
// ----------------------------------------------------------------------------
// async_frame_accumulator_ager
// Frame-tagged accumulating framebuffer with a negative-sample stash and
// time-based ageing of stale pixels.
//
// Input channel (in_valid_i / in_stall_o): one beat is a pixel sample
// (kind_i low) or a time tick (kind_i high). Output channel (out_valid_o /
// out_stall_i): one beat per sample, none per tick.
// A sample of the current or an older frame is read from the pixel store
// on intake, then updated and written back to it at its commit.
// A sample of a newer frame first sweeps the image to restart every pixel's
// age. A tick sweeps the image. This order of steps follows from the one
// read and one write port of the pixel memory.
// The result waits in an output register, so intake goes on while it is
// stalled; the next sample only holds before its commit if the register is
// still full.
// After reset the block clears the pixel memory, one entry a cycle, and
// stalls input until every entry is cleared; register writes are taken.
// The user writes registers only while the block is idle; the block itself does not enforce it.
// ----------------------------------------------------------------------------
`include "async_frame_accumulator_ager_defines.svh"

module async_frame_accumulator_ager (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [15:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               kind_i,
  input  logic [7:0]         pixel_x_i,
  input  logic [7:0]         pixel_y_i,
  input  logic [15:0]        frame_number_i,
  input  logic signed [23:0] red_in_i,
  input  logic signed [23:0] green_in_i,
  input  logic signed [23:0] blue_in_i,
  input  logic               batch_end_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [7:0]         out_x_o,
  output logic [7:0]         out_y_o,
  output logic signed [23:0] visible_red_o,
  output logic signed [23:0] visible_green_o,
  output logic signed [23:0] visible_blue_o,
  output logic [2:0]         outcome_o,
  output logic               saturated_o,
  output logic               batch_last_o
);

  afa_pkg::cmd_t    cmd;
  afa_pkg::status_t status;

  afa_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .status_i  (status),
    .cmd_o     (cmd),
    .in_stall_o(in_stall_o)
  );

  afa_datapath u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .in_valid_i     (in_valid_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .kind_i         (kind_i),
    .pixel_x_i      (pixel_x_i),
    .pixel_y_i      (pixel_y_i),
    .frame_number_i (frame_number_i),
    .red_in_i       (red_in_i),
    .green_in_i     (green_in_i),
    .blue_in_i      (blue_in_i),
    .batch_end_i    (batch_end_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .out_x_o        (out_x_o),
    .out_y_o        (out_y_o),
    .visible_red_o  (visible_red_o),
    .visible_green_o(visible_green_o),
    .visible_blue_o (visible_blue_o),
    .outcome_o      (outcome_o),
    .saturated_o    (saturated_o),
    .batch_last_o   (batch_last_o)
  );

  // A new result only ever appears right after a commit.
  `AFA_ASSERT(a_out_from_commit, $rose(out_valid_o) |-> $past(cmd.commit), "result without commit")
  // After a commit the block is ready for the next beat.
  `AFA_ASSERT(a_idle_after_commit, cmd.commit |=> !in_stall_o, "not idle after commit")
  // A commit never overwrites a result that is still stalled.
  `AFA_ASSERT_ALWAYS(a_commit_free, cmd.commit |-> (!out_valid_o || !out_stall_i), "result lost")

endmodule
